@@ src/integer_to_roman_numeral_macros.svh @@
// ----------------------------------------------------------------------------
// integer_to_roman_numeral assertion macros
// shared property forms for the roman numeral converter checks
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_ROMAN_NUMERAL_MACROS_SVH
`define INTEGER_TO_ROMAN_NUMERAL_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define IR_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define IR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/ir_pkg.sv @@
// ----------------------------------------------------------------------------
// ir_pkg
// shared types, constants and letter tables of the roman numeral converter
// ----------------------------------------------------------------------------
package ir_pkg;

    localparam int VALUE_W = 14;
    localparam int SYM_W   = 7;
    localparam int DIGIT_W = 4;

    localparam logic [VALUE_W-1:0] VALUE_MAX = 14'd9999;

    // double dabble takes one step per binary input bit
    localparam logic [3:0] SHIFT_LAST = 4'(VALUE_W - 1);

    // ascii letters
    localparam logic [SYM_W-1:0] LETTER_I = 7'd73;
    localparam logic [SYM_W-1:0] LETTER_V = 7'd86;
    localparam logic [SYM_W-1:0] LETTER_X = 7'd88;
    localparam logic [SYM_W-1:0] LETTER_L = 7'd76;
    localparam logic [SYM_W-1:0] LETTER_C = 7'd67;
    localparam logic [SYM_W-1:0] LETTER_D = 7'd68;
    localparam logic [SYM_W-1:0] LETTER_M = 7'd77;

    // letter roles within a decade
    localparam logic [1:0] SEL_ONE  = 2'd0;
    localparam logic [1:0] SEL_FIVE = 2'd1;
    localparam logic [1:0] SEL_TEN  = 2'd2;

    // digit positions, also the decade index for the lower three
    localparam logic [1:0] POS_UNITS = 2'd0;
    localparam logic [1:0] POS_TENS  = 2'd1;
    localparam logic [1:0] POS_HUNDS = 2'd2;
    localparam logic [1:0] POS_THOUS = 2'd3;

    typedef struct packed {
        logic [DIGIT_W-1:0] thou;
        logic [DIGIT_W-1:0] hund;
        logic [DIGIT_W-1:0] tens;
        logic [DIGIT_W-1:0] ones;
    } digits_t;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_SHIFT,
        FR_PUSH
    } front_state_t;

    // number of letters for a digit of a decade written in standard form
    function automatic logic [2:0] form_len(input logic [DIGIT_W-1:0] d);
        logic [2:0] len;
        unique case (d)
            4'd1, 4'd5:               len = 3'd1;
            4'd2, 4'd4, 4'd6, 4'd9:   len = 3'd2;
            4'd3, 4'd7:               len = 3'd3;
            4'd8:                     len = 3'd4;
            default:                  len = 3'd0;
        endcase
        return len;
    endfunction

    // role of letter idx within the form of digit d
    function automatic logic [1:0] form_sel(input logic [DIGIT_W-1:0] d,
                                           input logic [1:0] idx);
        logic [1:0] sel;
        unique case (d)
            4'd4:                sel = (idx == 2'd0) ? SEL_ONE : SEL_FIVE;
            4'd5:                sel = SEL_FIVE;
            4'd6, 4'd7, 4'd8:    sel = (idx == 2'd0) ? SEL_FIVE : SEL_ONE;
            4'd9:                sel = (idx == 2'd0) ? SEL_ONE : SEL_TEN;
            default:             sel = SEL_ONE;
        endcase
        return sel;
    endfunction

    function automatic logic [SYM_W-1:0] decade_letter(input logic [1:0] pos,
                                                       input logic [1:0] sel);
        logic [SYM_W-1:0] letter;
        unique case ({pos, sel})
            {POS_UNITS, SEL_ONE}:  letter = LETTER_I;
            {POS_UNITS, SEL_FIVE}: letter = LETTER_V;
            {POS_UNITS, SEL_TEN}:  letter = LETTER_X;
            {POS_TENS,  SEL_ONE}:  letter = LETTER_X;
            {POS_TENS,  SEL_FIVE}: letter = LETTER_L;
            {POS_TENS,  SEL_TEN}:  letter = LETTER_C;
            {POS_HUNDS, SEL_ONE}:  letter = LETTER_C;
            {POS_HUNDS, SEL_FIVE}: letter = LETTER_D;
            {POS_HUNDS, SEL_TEN}:  letter = LETTER_M;
            default:               letter = LETTER_M;
        endcase
        return letter;
    endfunction

    // highest nonzero digit position in a mask
    function automatic logic [1:0] top_pos(input logic [3:0] mask);
        logic [1:0] pos;
        priority if (mask[3]) pos = POS_THOUS;
        else if (mask[2])     pos = POS_HUNDS;
        else if (mask[1])     pos = POS_TENS;
        else                  pos = POS_UNITS;
        return pos;
    endfunction

    // positions below pos
    function automatic logic [3:0] below_mask(input logic [1:0] pos);
        logic [3:0] mask;
        unique case (pos)
            POS_THOUS: mask = 4'b0111;
            POS_HUNDS: mask = 4'b0011;
            POS_TENS:  mask = 4'b0001;
            default:   mask = 4'b0000;
        endcase
        return mask;
    endfunction

endpackage

@@ src/ir_front.sv @@
// ----------------------------------------------------------------------------
// ir_front
// takes a number, clamps it and splits it into decimal digits by double dabble
// ----------------------------------------------------------------------------
module ir_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    output logic                        item_stall,
    input  logic [ir_pkg::VALUE_W-1:0]  value,
    output logic                        push,
    output ir_pkg::digits_t             push_digits,
    input  logic                        full
);

    ir_pkg::front_state_t        state_reg, state_next;
    logic [3:0]                  cnt_reg, cnt_next;
    logic [15:0]                 bcd_reg, bcd_next;
    logic [ir_pkg::VALUE_W-1:0]  bin_reg, bin_next;
    logic [15:0]                 adj;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ir_pkg::FR_IDLE;
            cnt_reg   <= 4'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bcd_reg <= bcd_next;
        bin_reg <= bin_next;
    end

    // add 3 to every bcd digit of 5 or more before the shift
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            adj[4*i +: 4] = (bcd_reg[4*i +: 4] >= 4'd5) ? bcd_reg[4*i +: 4] + 4'd3
                                                        : bcd_reg[4*i +: 4];
        end
    end

    assign item_stall  = (state_reg != ir_pkg::FR_IDLE);
    assign push_digits = '{thou: bcd_reg[15:12], hund: bcd_reg[11:8],
                           tens: bcd_reg[7:4],   ones: bcd_reg[3:0]};

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        bcd_next   = bcd_reg;
        bin_next   = bin_reg;
        push       = 1'b0;
        unique case (state_reg)
            ir_pkg::FR_IDLE:
            begin
                if (item_valid)
                begin
                    bin_next   = (value > ir_pkg::VALUE_MAX) ? ir_pkg::VALUE_MAX : value;
                    bcd_next   = 16'd0;
                    cnt_next   = 4'd0;
                    state_next = ir_pkg::FR_SHIFT;
                end
            end
            ir_pkg::FR_SHIFT:
            begin
                bcd_next = {adj[14:0], bin_reg[ir_pkg::VALUE_W-1]};
                bin_next = {bin_reg[ir_pkg::VALUE_W-2:0], 1'b0};
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == ir_pkg::SHIFT_LAST)
                begin
                    state_next = ir_pkg::FR_PUSH;
                end
            end
            ir_pkg::FR_PUSH:
            begin
                push = !full;
                if (!full)
                begin
                    state_next = ir_pkg::FR_IDLE;
                end
            end
            default:
            begin
                state_next = ir_pkg::FR_IDLE;
            end
        endcase
    end

endmodule

@@ src/ir_queue.sv @@
// ----------------------------------------------------------------------------
// ir_queue
// two-entry digit queue between the converter front and the letter sequencer
// ----------------------------------------------------------------------------
module ir_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  ir_pkg::digits_t  push_data,
    output logic             full,
    input  logic             pop,
    output ir_pkg::digits_t  pop_data,
    output logic             empty
);

    ir_pkg::digits_t  slot0_reg, slot1_reg;
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_data = rd_ptr_reg ? slot1_reg : slot0_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !wr_ptr_reg)
        begin
            slot0_reg <= push_data;
        end
        if (push && wr_ptr_reg)
        begin
            slot1_reg <= push_data;
        end
    end

endmodule

@@ src/ir_back.sv @@
// ----------------------------------------------------------------------------
// ir_back
// walks one number's digits and emits one numeral letter per unstalled cycle
// ----------------------------------------------------------------------------
module ir_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       empty,
    output logic                       pop,
    input  ir_pkg::digits_t            pop_data,
    output logic                       result_valid,
    input  logic                       result_stall,
    output logic [ir_pkg::SYM_W-1:0]   symbol,
    output logic                       last
);

    logic                        busy_reg, busy_next;
    ir_pkg::digits_t             dig_reg, dig_next;
    logic [1:0]                  pos_reg, pos_next;
    logic [3:0]                  cnt_reg, cnt_next;
    logic                        out_valid_reg, out_valid_next;
    logic [ir_pkg::SYM_W-1:0]    symbol_reg, symbol_next;
    logic                        last_reg, last_next;

    logic [3:0]                  nz, in_nz, lower;
    logic [ir_pkg::DIGIT_W-1:0]  cur;
    logic [3:0]                  len;
    logic [ir_pkg::SYM_W-1:0]    letter;
    logic                        digit_end, emit;

    always_comb
    begin
        nz    = {dig_reg.thou != 4'd0, dig_reg.hund != 4'd0,
                 dig_reg.tens != 4'd0, dig_reg.ones != 4'd0};
        in_nz = {pop_data.thou != 4'd0, pop_data.hund != 4'd0,
                 pop_data.tens != 4'd0, pop_data.ones != 4'd0};
        unique case (pos_reg)
            ir_pkg::POS_THOUS: cur = dig_reg.thou;
            ir_pkg::POS_HUNDS: cur = dig_reg.hund;
            ir_pkg::POS_TENS:  cur = dig_reg.tens;
            default:           cur = dig_reg.ones;
        endcase
        // thousands are plain runs of M
        if (pos_reg == ir_pkg::POS_THOUS)
        begin
            len    = cur;
            letter = ir_pkg::LETTER_M;
        end
        else
        begin
            len    = {1'b0, ir_pkg::form_len(cur)};
            letter = ir_pkg::decade_letter(pos_reg, ir_pkg::form_sel(cur, cnt_reg[1:0]));
        end
        lower     = nz & ir_pkg::below_mask(pos_reg);
        digit_end = (cnt_reg + 4'd1 == len);
        emit      = busy_reg && (!out_valid_reg || !result_stall);
        pop       = !busy_reg && !empty;
    end

    always_comb
    begin
        busy_next      = busy_reg;
        dig_next       = dig_reg;
        pos_next       = pos_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        symbol_next    = symbol_reg;
        last_next      = last_reg;

        // an all-zero item yields no letters and is dropped here
        if (pop)
        begin
            dig_next  = pop_data;
            busy_next = |in_nz;
            pos_next  = ir_pkg::top_pos(in_nz);
            cnt_next  = 4'd0;
        end

        if (emit)
        begin
            out_valid_next = 1'b1;
            symbol_next    = letter;
            last_next      = digit_end && (lower == 4'd0);
            if (digit_end)
            begin
                cnt_next = 4'd0;
                if (lower == 4'd0)
                begin
                    busy_next = 1'b0;
                end
                else
                begin
                    pos_next = ir_pkg::top_pos(lower);
                end
            end
            else
            begin
                cnt_next = cnt_reg + 4'd1;
            end
        end
        else if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg       <= ir_pkg::POS_UNITS;
            cnt_reg       <= 4'd0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
            pos_reg       <= pos_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dig_reg    <= dig_next;
        symbol_reg <= symbol_next;
        last_reg   <= last_next;
    end

    assign result_valid = out_valid_reg;
    assign symbol       = symbol_reg;
    assign last         = last_reg;

endmodule

@@ src/integer_to_roman_numeral.sv @@
// ----------------------------------------------------------------------------
// integer_to_roman_numeral
// converts numbers 0 to 9999 into roman numeral letters, one item per letter
// ----------------------------------------------------------------------------
// Each accepted number is clamped to 9999 and split into decimal digits by a
// double dabble front end. The front captures a number, runs 14 shift steps
// and then writes the queue, so after an accept it holds item_stall high
// through the shift steps and the queue write, and longer while the queue is
// full. The digits then wait in a two-entry queue until the letter sequencer
// takes them; it first loads a number into its digit register and then sends
// one ASCII letter per cycle while result_stall is low, with last set on the
// final letter; the worst case is a 21-letter numeral. A zero input gives no
// letters. The front and back overlap, so the front converts the next number
// while letters of the previous one are still going out.
`include "integer_to_roman_numeral_macros.svh"

module integer_to_roman_numeral (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    output logic                        item_stall,
    input  logic [ir_pkg::VALUE_W-1:0]  value,
    output logic                        result_valid,
    input  logic                        result_stall,
    output logic [ir_pkg::SYM_W-1:0]    symbol,
    output logic                        last
);

    logic             q_push, q_full, q_pop, q_empty;
    ir_pkg::digits_t  q_push_data, q_pop_data;

    ir_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .value       (value),
        .push        (q_push),
        .push_digits (q_push_data),
        .full        (q_full)
    );

    ir_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .empty     (q_empty)
    );

    ir_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .empty        (q_empty),
        .pop          (q_pop),
        .pop_data     (q_pop_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .symbol       (symbol),
        .last         (last)
    );

    // only numeral letters ever leave the block
    `IR_ASSERT_IMPL(a_letter_legal, result_valid, (symbol == ir_pkg::LETTER_I) || (symbol == ir_pkg::LETTER_V) || (symbol == ir_pkg::LETTER_X) || (symbol == ir_pkg::LETTER_L) || (symbol == ir_pkg::LETTER_C) || (symbol == ir_pkg::LETTER_D) || (symbol == ir_pkg::LETTER_M), "illegal numeral letter")
    // an accepted item keeps the front busy while it converts
    `IR_ASSERT_NEXT(a_front_busy, item_valid && !item_stall, item_stall, "front took a second item during conversion")
    // the sequencer never pops an empty queue
    `IR_ASSERT_IMPL(a_no_underflow, q_pop, !q_empty, "digit queue underflow")

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the integer to roman numeral converter
// ----------------------------------------------------------------------------
// Sends a table of hand-picked numbers, then about 350 random ones, through
// the item channel. Each accepted number is spelled into the letters it
// should give, and every letter that comes out is compared with the oldest
// letter still pending. The sender works in bursts and the receiver stalls
// on its own pattern. Once, the receiver holds off long enough to fill the
// block, and once, the sender waits for the block to drain.
// ----------------------------------------------------------------------------
module tb_top;

    typedef logic [ir_pkg::VALUE_W-1:0] value_t;

    typedef struct packed {
        logic [ir_pkg::SYM_W-1:0] symbol;
        logic                     last;
    } letter_t;

    typedef struct {
        value_t value;
        bit     typed;
        string  numeral;
    } directed_row_t;

    localparam int RANDOM_NUMBERS = 350;
    localparam int HOLD_AFTER     = 60;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_AT       = 200;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     item_valid;
    logic                     item_stall;
    value_t                   value;
    logic                     result_valid;
    logic                     result_stall;
    logic [ir_pkg::SYM_W-1:0] symbol;
    logic                     last;

    letter_t pending_letters[$];
    int      errors = 0;
    int      numbers_accepted = 0;
    int      burst_left = 0;

    // typed rows carry the numeral as read off the letter rules
    directed_row_t directed_rows[23] = '{
        '{14'd0,     1'b1, ""},
        '{14'd1,     1'b1, "I"},
        '{14'd4,     1'b1, "IV"},
        '{14'd5,     1'b1, "V"},
        '{14'd9,     1'b1, "IX"},
        '{14'd14,    1'b0, ""},
        '{14'd40,    1'b0, ""},
        '{14'd49,    1'b0, ""},
        '{14'd90,    1'b0, ""},
        '{14'd400,   1'b0, ""},
        '{14'd444,   1'b0, ""},
        '{14'd900,   1'b0, ""},
        '{14'd1000,  1'b1, "M"},
        '{14'd1994,  1'b0, ""},
        '{14'd3888,  1'b0, ""},
        '{14'd9888,  1'b1, "MMMMMMMMMDCCCLXXXVIII"},
        '{14'd9999,  1'b1, "MMMMMMMMMCMXCIX"},
        '{14'd10000, 1'b1, "MMMMMMMMMCMXCIX"},
        '{14'd16383, 1'b1, "MMMMMMMMMCMXCIX"},
        '{14'd0,     1'b1, ""},
        '{14'd8191,  1'b0, ""},
        '{14'd5678,  1'b0, ""},
        '{14'd2763,  1'b0, ""}
    };

    integer_to_roman_numeral dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .value        (value),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .symbol       (symbol),
        .last         (last)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // spell one number and queue its letters
    function automatic void predict_numeral(input value_t v);
        logic [ir_pkg::SYM_W-1:0] word [21];
        logic [ir_pkg::SYM_W-1:0] one;
        logic [ir_pkg::SYM_W-1:0] five;
        logic [ir_pkg::SYM_W-1:0] ten;
        int rest;
        int n;
        int d;
        int decade;
        int k;
        rest = (v > ir_pkg::VALUE_MAX) ? int'(ir_pkg::VALUE_MAX) : int'(v);
        n = 0;
        for (k = 0; k < rest / 1000; k++)
        begin
            word[n] = ir_pkg::LETTER_M;
            n++;
        end
        for (decade = int'(ir_pkg::POS_HUNDS); decade >= int'(ir_pkg::POS_UNITS); decade--)
        begin
            case (decade)
                int'(ir_pkg::POS_HUNDS):
                begin
                    d = (rest / 100) % 10;
                    one = ir_pkg::LETTER_C; five = ir_pkg::LETTER_D; ten = ir_pkg::LETTER_M;
                end
                int'(ir_pkg::POS_TENS):
                begin
                    d = (rest / 10) % 10;
                    one = ir_pkg::LETTER_X; five = ir_pkg::LETTER_L; ten = ir_pkg::LETTER_C;
                end
                default:
                begin
                    d = rest % 10;
                    one = ir_pkg::LETTER_I; five = ir_pkg::LETTER_V; ten = ir_pkg::LETTER_X;
                end
            endcase
            case (d)
                4:
                begin
                    word[n] = one; word[n + 1] = five; n += 2;
                end
                9:
                begin
                    word[n] = one; word[n + 1] = ten; n += 2;
                end
                default:
                begin
                    if (d >= 5)
                    begin
                        word[n] = five;
                        n++;
                        d -= 5;
                    end
                    for (k = 0; k < d; k++)
                    begin
                        word[n] = one;
                        n++;
                    end
                end
            endcase
        end
        for (k = 0; k < n; k++)
            pending_letters.push_back(letter_t'{symbol: word[k], last: (k == n - 1)});
    endfunction

    // offer one item, holding it until accepted; the sender idles between bursts
    task automatic offer_number(input value_t v, input bit typed,
                                input string numeral);
        byte ch;
        int  i;
        if (burst_left == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
        end
        burst_left--;
        item_valid <= 1'b1;
        value      <= v;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        numbers_accepted++;
        if (typed)
        begin
            for (i = 0; i < numeral.len(); i++)
            begin
                ch = numeral[i];
                pending_letters.push_back(letter_t'{symbol: ch[6:0],
                                                    last: (i == numeral.len() - 1)});
            end
        end
        else
            predict_numeral(v);
    endtask

    initial
    begin : stimulus
        value_t v;
        int k;
        rst_n      <= 1'b0;
        item_valid <= 1'b0;
        value      <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
            offer_number(directed_rows[r].value, directed_rows[r].typed,
                         directed_rows[r].numeral);

        for (k = 0; k < RANDOM_NUMBERS; k++)
        begin
            case ($urandom_range(0, 19))
                0:       v = '0;
                1, 2:    v = value_t'($urandom_range(1, 99));
                3, 4:    v = value_t'($urandom_range(100, 999));
                5:       v = value_t'($urandom_range(10000, 16383));
                6:       v = value_t'($urandom);
                default: v = value_t'($urandom_range(1000, 9999));
            endcase
            // sender pauses until the block has sent everything
            if (k == DRAIN_AT)
            begin
                item_valid <= 1'b0;
                do
                    @(posedge clk);
                while (pending_letters.size() != 0);
                burst_left = $urandom_range(1, 8);
            end
            offer_number(v, 1'b0, "");
        end

        item_valid <= 1'b0;
        while (pending_letters.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // receiver stall pattern, with one long hold-off to back the block up
    initial
    begin : receiver
        int  pct;
        int  run;
        bit  held;
        held = 1'b0;
        result_stall <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (!held && numbers_accepted >= HOLD_AFTER)
            begin
                held = 1'b1;
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0:       pct = 0;
                    1:       pct = 25;
                    2:       pct = 50;
                    default: pct = 85;
                endcase
                run = $urandom_range(20, 120);
                repeat (run)
                begin
                    result_stall <= ($urandom_range(0, 99) < pct);
                    @(posedge clk);
                end
            end
        end
    end

    always @(posedge clk)
    begin : letter_check
        letter_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_letters.size() == 0)
            begin
                $display("%0t: unexpected letter: expected none, actual %c last %b",
                         $time, symbol, last);
                errors++;
            end
            else
            begin
                want = pending_letters.pop_front();
                if (symbol !== want.symbol)
                begin
                    $display("%0t: symbol mismatch: expected %c (%0d), actual %c (%0d)",
                             $time, want.symbol, want.symbol, symbol, symbol);
                    errors++;
                end
                if (last !== want.last)
                begin
                    $display("%0t: last mismatch: expected %b, actual %b",
                             $time, want.last, last);
                    errors++;
                end
            end
        end
    end

    initial
    begin : watchdog
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
